### design/rmgm_pkg.sv
// Package for the running-mean Gram matrix block.
// Holds payload structs, sizes, the back-end state enum and the queue entry type.
// No dependencies.
package rmgm_pkg;

	localparam int NUM_AMPLITUDES = 8;
	localparam int COUNT_BITS = 32;
	localparam int IDX_BITS = 3;
	localparam int NPAIRS = (NUM_AMPLITUDES * (NUM_AMPLITUDES - 1)) / 2;
	localparam int NENTRIES = NUM_AMPLITUDES + NPAIRS;
	localparam int ENT_BITS = $clog2(NENTRIES + 1);
	localparam int QDEPTH = 2;
	localparam int QPTR_BITS = 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic [2:0] index;
		logic signed [31:0] amp_re;
		logic signed [31:0] amp_im;
		logic last_element;
		logic restart;
	} in_item_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
		logic signed [63:0] mean_re;
		logic signed [63:0] mean_im;
		logic last;
	} out_item_t;

	// One finished point handed from the front to the back.
	typedef struct packed {
		logic [NUM_AMPLITUDES-1:0][63:0] amps;
		logic [COUNT_BITS-1:0] count;
	} point_job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUM,
		BK_DELTA,
		BK_DIV,
		BK_ADD,
		BK_NEXT,
		BK_EMIT
	} bk_state_t;

	// Saturating signed 64-bit add.
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) sat_add64 = s[64] ? S64_MIN : S64_MAX;
		else sat_add64 = s[63:0];
	endfunction

endpackage

### design/rmgm_front.sv
// Front end: buffers amplitudes and keeps the point count.
// Depends on rmgm_pkg.
module rmgm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rmgm_pkg::in_item_t    in_data,
	output logic                  job_valid,
	input  logic                  job_ready,
	output rmgm_pkg::point_job_t  job
);

	logic [rmgm_pkg::NUM_AMPLITUDES-1:0][63:0] buf_q;
	logic [rmgm_pkg::COUNT_BITS-1:0] count_q;
	logic [rmgm_pkg::COUNT_BITS-1:0] cnt_base;
	logic fire;

	// Only a completing element needs room in the queue.
	assign in_ready = !in_data.last_element || job_ready;
	assign fire = in_valid && in_ready;
	assign cnt_base = in_data.restart ? '0 : count_q;

	// Build the job from the buffer with this element merged in.
	always_comb begin
		job.amps = buf_q;
		if (32'(in_data.index) < rmgm_pkg::NUM_AMPLITUDES)
			job.amps[in_data.index] = {in_data.amp_re, in_data.amp_im};
		job.count = (cnt_base == rmgm_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
	end
	assign job_valid = in_valid && in_data.last_element;

	// Point counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= in_data.last_element ? job.count : cnt_base;
		end
	end

	// Amplitude buffer.
	always_ff @(posedge clk) begin
		if (fire && 32'(in_data.index) < rmgm_pkg::NUM_AMPLITUDES)
			buf_q[in_data.index] <= {in_data.amp_re, in_data.amp_im};
	end

endmodule

### design/rmgm_queue.sv
// Short queue of finished points between front and back.
// Depends on rmgm_pkg.
module rmgm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  rmgm_pkg::point_job_t  wr_data,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output rmgm_pkg::point_job_t  rd_data
);

	rmgm_pkg::point_job_t mem_q [rmgm_pkg::QDEPTH];
	logic [rmgm_pkg::QPTR_BITS-1:0] wp_q, rp_q;
	logic [rmgm_pkg::QPTR_BITS:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(rmgm_pkg::QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

### design/rmgm_back.sv
// Back end: updates every mean with a serial divider and emits results.
// Depends on rmgm_pkg.
module rmgm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  rmgm_pkg::point_job_t  job,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rmgm_pkg::out_item_t   out_data
);

	rmgm_pkg::bk_state_t state_q, state_d;
	rmgm_pkg::point_job_t job_q;
	// Means in emission order: entry e holds (re, im); im unused on diagonals.
	logic signed [63:0] mre_q [rmgm_pkg::NENTRIES];
	logic signed [63:0] mim_q [rmgm_pkg::NENTRIES];
	logic [rmgm_pkg::NENTRIES-1:0] vld_q;
	logic [2:0] i_q, j_q;
	logic [rmgm_pkg::ENT_BITS-1:0] e_q;
	logic [rmgm_pkg::ENT_BITS-1:0] e_nx;
	logic part_q; // 0 = real part, 1 = imaginary part
	logic [1:0] mc_q;
	logic signed [63:0] p_q [4];
	logic signed [63:0] samp_q, mean_q, d_q;
	logic signed [63:0] ore_q, oim_q;
	logic dneg_q;
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic [6:0] bit_q;
	logic signed [31:0] ri, ii, rj, ij, ma, mb;
	logic signed [63:0] prod;
	logic signed [64:0] ssum, dsub;
	logic [64:0] rtry;
	logic [rmgm_pkg::COUNT_BITS-1:0] dv;
	logic signed [63:0] qs;
	logic diag;

	assign diag = i_q == j_q;
	assign ri = job_q.amps[i_q][63:32];
	assign ii = job_q.amps[i_q][31:0];
	assign rj = job_q.amps[j_q][63:32];
	assign ij = job_q.amps[j_q][31:0];
	assign e_nx = e_q + 1'b1;
	assign dv = (job_q.count == '0) ? {{(rmgm_pkg::COUNT_BITS-1){1'b0}}, 1'b1} : job_q.count;

	// One multiplier, four products in turn.
	always_comb begin
		case (mc_q)
			2'd0: begin ma = ri; mb = rj; end
			2'd1: begin ma = ii; mb = ij; end
			2'd2: begin ma = ri; mb = ij; end
			default: begin ma = ii; mb = rj; end
		endcase
		prod = ma * mb;
		if (!part_q) ssum = {p_q[0][63], p_q[0]} + {p_q[1][63], p_q[1]};
		else ssum = {p_q[2][63], p_q[2]} - {p_q[3][63], p_q[3]};
		dsub = {samp_q[63], samp_q} - {mean_q[63], mean_q};
		rtry = {rem_q[63:0], d_q[63]};
		qs = dneg_q ? -$signed(quo_q) : $signed(quo_q);
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			rmgm_pkg::BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = rmgm_pkg::BK_MUL;
			end
			rmgm_pkg::BK_MUL: if (mc_q == 2'd3) state_d = rmgm_pkg::BK_SUM;
			rmgm_pkg::BK_SUM: state_d = rmgm_pkg::BK_DELTA;
			rmgm_pkg::BK_DELTA: state_d = rmgm_pkg::BK_DIV;
			rmgm_pkg::BK_DIV: if (bit_q == 7'd63) state_d = rmgm_pkg::BK_ADD;
			rmgm_pkg::BK_ADD: state_d = rmgm_pkg::BK_NEXT;
			rmgm_pkg::BK_NEXT: begin
				if (!part_q && !diag) state_d = rmgm_pkg::BK_SUM;
				else if (32'(e_q) == rmgm_pkg::NENTRIES - 1) state_d = rmgm_pkg::BK_EMIT;
				else state_d = rmgm_pkg::BK_MUL;
			end
			rmgm_pkg::BK_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && 32'(e_q) == rmgm_pkg::NENTRIES - 1)
					state_d = rmgm_pkg::BK_IDLE;
			end
			default: state_d = rmgm_pkg::BK_IDLE;
		endcase
	end

	assign out_data.row = i_q;
	assign out_data.col = j_q;
	assign out_data.mean_re = ore_q;
	assign out_data.mean_im = diag ? '0 : oim_q;
	assign out_data.last = 32'(e_q) == rmgm_pkg::NENTRIES - 1;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmgm_pkg::BK_IDLE;
			vld_q <= '0;
			i_q <= '0;
			j_q <= '0;
			e_q <= '0;
			part_q <= 1'b0;
			mc_q <= '0;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rmgm_pkg::BK_IDLE: begin
					i_q <= '0; j_q <= '0; e_q <= '0; part_q <= 1'b0; mc_q <= '0;
				end
				rmgm_pkg::BK_MUL: mc_q <= mc_q + 1'b1;
				rmgm_pkg::BK_DELTA: bit_q <= '0;
				rmgm_pkg::BK_DIV: bit_q <= bit_q + 1'b1;
				rmgm_pkg::BK_ADD: if (part_q || diag) vld_q[e_q] <= 1'b1;
				rmgm_pkg::BK_NEXT: begin
					if (!part_q && !diag) begin
						part_q <= 1'b1;
					end else begin
						part_q <= 1'b0;
						if (32'(e_q) != rmgm_pkg::NENTRIES - 1) begin
							e_q <= e_q + 1'b1;
							if (32'(j_q) == rmgm_pkg::NUM_AMPLITUDES - 1) begin
								i_q <= i_q + 1'b1; j_q <= i_q + 1'b1;
							end else j_q <= j_q + 1'b1;
						end else begin
							e_q <= '0; i_q <= '0; j_q <= '0;
						end
					end
				end
				rmgm_pkg::BK_EMIT: if (out_ready) begin
					e_q <= e_q + 1'b1;
					if (32'(j_q) == rmgm_pkg::NUM_AMPLITUDES - 1) begin
						i_q <= i_q + 1'b1; j_q <= i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			rmgm_pkg::BK_IDLE: if (job_valid) job_q <= job;
			rmgm_pkg::BK_MUL: p_q[mc_q] <= prod;
			rmgm_pkg::BK_SUM: begin
				// Exact sum, then floor shift by 16; the diagonal uses ri*ri + ii*ii.
				samp_q <= 64'(ssum >>> 16);
				// A mean not yet written since reset reads as zero.
				mean_q <= vld_q[e_q] ? (part_q ? mim_q[e_q] : mre_q[e_q]) : '0;
			end
			rmgm_pkg::BK_DELTA: begin
				// Saturate the delta and keep its magnitude for the divider.
				if (dsub[64] != dsub[63]) d_q <= dsub[64] ? rmgm_pkg::S64_MIN : rmgm_pkg::S64_MAX;
				else if (dsub[64]) d_q <= -dsub[63:0];
				else d_q <= dsub[63:0];
				dneg_q <= dsub[64];
				rem_q <= '0;
			end
			rmgm_pkg::BK_DIV: begin
				// Restoring divide on the magnitude, one bit per cycle.
				if (rtry >= 65'(dv)) begin
					rem_q <= rtry - 65'(dv);
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rtry;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				d_q <= {d_q[62:0], 1'b0};
			end
			rmgm_pkg::BK_ADD: begin
				if (part_q) mim_q[e_q] <= rmgm_pkg::sat_add64(mean_q, qs);
				else mre_q[e_q] <= rmgm_pkg::sat_add64(mean_q, qs);
			end
			rmgm_pkg::BK_NEXT: begin
				// Fetch the first entry ahead of the emit phase.
				ore_q <= mre_q[0];
				oim_q <= mim_q[0];
			end
			rmgm_pkg::BK_EMIT: if (out_ready && 32'(e_q) != rmgm_pkg::NENTRIES - 1) begin
				// Fetch the next entry while the current one is taken.
				ore_q <= mre_q[e_nx];
				oim_q <= mim_q[e_nx];
			end
			default: ;
		endcase
	end

endmodule

### design/running_mean_gram_matrix_top.sv
// Top level of the running-mean Gram matrix block.
// Depends on rmgm_pkg, rmgm_front, rmgm_queue and rmgm_back.
//
// Usage: amplitudes enter on the in channel (valid/ready), one per
// transaction, tagged with their index. A transaction with last_element
// set completes a data point; its buffer snapshot and point count go into a
// two-entry queue. The back end then updates all 36 means one after another
// (real and imaginary parts separately): a shared 32x32 multiplier forms
// the four products of each entry, then each part passes through add and
// saturate steps and a bit-serial divider, after which the 36 means stream
// out on the out channel in row-major order, one per cycle while the
// receiver is ready, last set on the final one. Non-final elements are
// taken every cycle; a final element waits only while the queue is full.
// When the receiver stalls, the back end holds the current result and the
// queue fills. Reset clears the point count and the queue and marks all
// means unwritten, so they read as zero; the amplitude buffer is not reset.
module running_mean_gram_matrix_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rmgm_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rmgm_pkg::out_item_t  out_data
);

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	rmgm_pkg::point_job_t fq_job, qb_job;

	rmgm_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job));
	rmgm_queue u_queue (.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
		.wr_data(fq_job), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job));
	rmgm_back u_back (.clk, .arst_n, .job_valid(qb_valid), .job_ready(qb_ready),
		.job(qb_job), .out_valid, .out_ready, .out_data);

endmodule

### design/rmgm_checker.sv
// Port-level checker for the running-mean Gram matrix block.
// Depends on rmgm_pkg; bound to running_mean_gram_matrix_top.
module rmgm_props (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input rmgm_pkg::in_item_t   in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input rmgm_pkg::out_item_t  out_data
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Entries never fall below the diagonal.
	a_tri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.col >= out_data.row)
		else $error("entry below diagonal");

	// Diagonal entries have no imaginary part.
	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.col == out_data.row |-> out_data.mean_im == '0)
		else $error("diagonal imaginary part nonzero");

	// Non-final elements are always taken.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_data.last_element |-> in_ready)
		else $error("non-final element stalled");

endmodule

bind running_mean_gram_matrix_top rmgm_props u_rmgm_props (.*);
